// ----- hw/rtl/lr_pkg.sv -----
package lr_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	localparam logic [11:0] X_MAX = 12'(SCREEN_WIDTH - 1);
	localparam logic [11:0] Y_MAX = 12'(SCREEN_HEIGHT - 1);

	// Request kinds carried on the input tuser.
	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_t;

	// One pixel result as it leaves the Bresenham core.
	typedef struct packed {
		logic       valid_res;
		logic [9:0] x;
		logic [8:0] y;
		logic [7:0] color;
		logic       last;
	} pixel_t;

	// Clamp a signed coordinate into 0..hi.
	function automatic logic [11:0] clamp_coord(input logic signed [11:0] v,
			input logic [11:0] hi);
		logic [11:0] r;
		if (v < 0) begin
			r = '0;
		end else if ($unsigned(v) > hi) begin
			r = hi;
		end else begin
			r = $unsigned(v);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/line_rasterizer.sv -----
// Bresenham line rasterizer for a byte-per-pixel frame buffer.
// A request's pixel is registered in stage one, then in the output register.
// Throughput: one request per cycle unless the pixel side stalls; the Bresenham state
// update for the next pixel is combinational; the address add sits in stage two.
// Reset (arst_n low, asynchronous) clears frame_base, the line state and both stages;
// after reset no line is active.
module line_rasterizer import lr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: frame_base, the byte address of pixel (0,0).
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Request side.
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end, [55:48] color
	input  logic [55:0] s_tdata,
	// [0] func
	input  logic [0:0]  s_tuser,
	// Pixel side.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] pixel_x, [18:10] pixel_y, [50:19] pixel_address, [58:51] pix_color,
	// [63:59] zero
	output logic [63:0] m_tdata,
	// [0] valid_res
	output logic [0:0]  m_tuser,
	output logic        m_tlast
);

	logic [31:0] frame_base_q;

	logic   valid_s1, valid_s2;
	pixel_t pix_s1, pix_core;
	logic   adv_s2, accept;

	logic [9:0]  x_s2;
	logic [8:0]  y_s2;
	logic [31:0] addr_s2;
	logic [7:0]  color_s2;
	logic        last_s2;
	logic        vres_s2;
	logic [31:0] addr_next;

	// Configuration writes are taken at any time; the block is idle by contract.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
		end else if (cfg_valid) begin
			frame_base_q <= cfg_data;
		end
	end

	// The output register frees up when it is empty or being drained, and
	// stage one moves forward whenever stage two can take it. A new request
	// is accepted while a finished pixel waits downstream only if stage one is empty.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	// The core holds the line state and updates it on each accepted request.
	lr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.func    (func_t'(s_tuser[0])),
		.x_start ($signed(s_tdata[11:0])),
		.y_start ($signed(s_tdata[23:12])),
		.x_end   ($signed(s_tdata[35:24])),
		.y_end   ($signed(s_tdata[47:36])),
		.color   (s_tdata[55:48]),
		.pixel   (pix_core)
	);

	// Stage one: the pixel coordinates as computed by the core.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_core;
		end
	end

	// Row times the screen width is a constant multiply, which reduces to
	// two shifted adds for a 640-pixel row. A step with no line in progress
	// reports an all-zero result, address included.
	assign addr_next = pix_s1.valid_res ?
		frame_base_q + 32'(pix_s1.y) * 32'(SCREEN_WIDTH) + 32'(pix_s1.x) : '0;

	// Stage two: the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			x_s2     <= pix_s1.x;
			y_s2     <= pix_s1.y;
			addr_s2  <= addr_next;
			color_s2 <= pix_s1.color;
			last_s2  <= pix_s1.last;
			vres_s2  <= pix_s1.valid_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, color_s2, addr_s2, y_s2, x_s2};
	assign m_tuser  = vres_s2;
	assign m_tlast  = last_s2;

endmodule

// ----- hw/rtl/lr_core.sv -----
module lr_core import lr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  func_t              func,
	input  logic signed [11:0] x_start,
	input  logic signed [11:0] y_start,
	input  logic signed [11:0] x_end,
	input  logic signed [11:0] y_end,
	input  logic [7:0]         color,
	output pixel_t             pixel
);

	logic [9:0]        cur_x_q, cur_x_d;
	logic [8:0]        cur_y_q, cur_y_d;
	logic signed [11:0] err_q, err_d;
	logic [9:0]        major_q, major_d;
	logic [9:0]        minor_q, minor_d;
	logic [1:0]        sx_q, sx_d;
	logic [1:0]        sy_q, sy_d;
	logic              swap_q, swap_d;
	logic [9:0]        left_q, left_d;
	logic [7:0]        color_q, color_d;
	logic              active_q, active_d;

	logic [11:0] xa, ya, xb, yb;
	logic [9:0]  dx, dy;
	logic [1:0]  sgn_x, sgn_y;
	logic        minor_step;
	logic signed [12:0] err_sum;

	assign xa = clamp_coord(x_start, X_MAX);
	assign ya = clamp_coord(y_start, Y_MAX);
	assign xb = clamp_coord(x_end, X_MAX);
	assign yb = clamp_coord(y_end, Y_MAX);

	always_comb begin
		if (xb < xa) begin
			dx    = 10'(xa - xb);
			sgn_x = 2'b11;
		end else begin
			dx    = 10'(xb - xa);
			sgn_x = (xb == xa) ? 2'b00 : 2'b01;
		end
		if (yb < ya) begin
			dy    = 10'(ya - yb);
			sgn_y = 2'b11;
		end else begin
			dy    = 10'(yb - ya);
			sgn_y = (yb == ya) ? 2'b00 : 2'b01;
		end
	end

	assign minor_step = !err_q[11];

	always_comb begin
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		err_d    = err_q;
		major_d  = major_q;
		minor_d  = minor_q;
		sx_d     = sx_q;
		sy_d     = sy_q;
		swap_d   = swap_q;
		left_d   = left_q;
		color_d  = color_q;
		active_d = active_q;
		err_sum  = '0;
		pixel    = '0;
		case (func)
			FUNC_START: begin
				swap_d   = dy > dx;
				major_d  = swap_d ? dy : dx;
				minor_d  = swap_d ? dx : dy;
				err_d    = $signed({1'b0, minor_d, 1'b0}) - $signed({2'b00, major_d});
				sx_d     = sgn_x;
				sy_d     = sgn_y;
				cur_x_d  = xa[9:0];
				cur_y_d  = ya[8:0];
				color_d  = color;
				left_d   = major_d;
				active_d = major_d != '0;
				pixel    = '{valid_res: 1'b1, x: cur_x_d, y: cur_y_d,
					color: color_d, last: !active_d};
			end
			FUNC_STEP: begin
				if (active_q) begin
					// Major axis always advances; minor axis only when the
					// error term is non-negative.
					if (swap_q) begin
						cur_y_d = cur_y_q + {{7{sy_q[1]}}, sy_q};
						if (minor_step) begin
							cur_x_d = cur_x_q + {{8{sx_q[1]}}, sx_q};
						end
					end else begin
						cur_x_d = cur_x_q + {{8{sx_q[1]}}, sx_q};
						if (minor_step) begin
							cur_y_d = cur_y_q + {{7{sy_q[1]}}, sy_q};
						end
					end
					err_sum = {err_q[11], err_q} + $signed({2'b00, minor_q, 1'b0});
					if (minor_step) begin
						err_sum = err_sum - $signed({2'b00, major_q, 1'b0});
					end
					err_d    = err_sum[11:0];
					left_d   = left_q - 10'd1;
					active_d = left_d != '0;
					pixel    = '{valid_res: 1'b1, x: cur_x_d, y: cur_y_d,
						color: color_q, last: !active_d};
				end
			end
			default: begin
				pixel = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			err_q    <= '0;
			major_q  <= '0;
			minor_q  <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			swap_q   <= 1'b0;
			left_q   <= '0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			err_q    <= err_d;
			major_q  <= major_d;
			minor_q  <= minor_d;
			sx_q     <= sx_d;
			sy_q     <= sy_d;
			swap_q   <= swap_d;
			left_q   <= left_d;
			color_q  <= color_d;
			active_q <= active_d;
		end
	end

endmodule

// ----- dv/line_rasterizer_checker.sv -----
module line_rasterizer_checker import lr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end, [55:48] color
	input  logic [55:0] s_tdata,
	// [0] func
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] pixel_x, [18:10] pixel_y, [50:19] pixel_address, [58:51] pix_color,
	// [63:59] zero
	input  logic [63:0] m_tdata,
	// [0] valid_res
	input  logic [0:0]  m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic        valid_res;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [31:0] addr;
		logic [7:0]  color;
		logic        last;
	} pixel_exp_t;

	// Shadow of the register and of the line walker.
	logic [31:0] frame_base;
	logic [9:0]  pos_x;
	logic [8:0]  pos_y;
	int          err;
	int          major_d;
	int          minor_d;
	int          dir_x;
	int          dir_y;
	int          remaining;
	logic        steep;
	logic        drawing;
	logic [7:0]  ink;

	pixel_exp_t  pixel_q[$];

	function automatic int to_screen(logic signed [11:0] v, int limit);
		if (v < 0) begin
			return 0;
		end
		if (v >= limit) begin
			return limit - 1;
		end
		return int'(v);
	endfunction

	function automatic pixel_exp_t dot(logic fin);
		pixel_exp_t px;
		px.valid_res = 1'b1;
		px.x = pos_x;
		px.y = pos_y;
		px.addr = frame_base + 32'(pos_y) * 32'(SCREEN_WIDTH) + 32'(pos_x);
		px.color = ink;
		px.last = fin;
		return px;
	endfunction

	// Advances the walker by one request and returns the pixel it yields.
	function automatic pixel_exp_t rasterize(func_t f, logic [55:0] d);
		int xa, ya, xb, yb, dx, dy;
		pixel_exp_t px;
		px = '0;
		if (f == FUNC_START) begin
			xa = to_screen(d[11:0], SCREEN_WIDTH);
			ya = to_screen(d[23:12], SCREEN_HEIGHT);
			xb = to_screen(d[35:24], SCREEN_WIDTH);
			yb = to_screen(d[47:36], SCREEN_HEIGHT);
			dx = xb - xa;
			dy = yb - ya;
			dir_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
			dir_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
			if (dx < 0) begin
				dx = -dx;
			end
			if (dy < 0) begin
				dy = -dy;
			end
			steep = dy > dx;
			major_d = steep ? dy : dx;
			minor_d = steep ? dx : dy;
			err = 2 * minor_d - major_d;
			pos_x = 10'(xa);
			pos_y = 9'(ya);
			ink = d[55:48];
			remaining = major_d;
			drawing = remaining != 0;
			px = dot(!drawing);
		end else if (drawing) begin
			if (err >= 0) begin
				if (steep) begin
					pos_x = 10'(int'(pos_x) + dir_x);
				end else begin
					pos_y = 9'(int'(pos_y) + dir_y);
				end
				err -= 2 * major_d;
			end
			if (steep) begin
				pos_y = 9'(int'(pos_y) + dir_y);
			end else begin
				pos_x = 10'(int'(pos_x) + dir_x);
			end
			err += 2 * minor_d;
			remaining--;
			drawing = remaining != 0;
			px = dot(!drawing);
		end
		return px;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
					want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_exp_t want;
		if (!arst_n) begin
			frame_base = '0;
			pos_x = '0;
			pos_y = '0;
			err = 0;
			major_d = 0;
			minor_d = 0;
			dir_x = 0;
			dir_y = 0;
			remaining = 0;
			steep = 1'b0;
			drawing = 1'b0;
			ink = '0;
			pixel_q.delete();
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_base = cfg_data;
			end
			// Results are matched before this edge's request is queued, so a result that
			// shows up too early is never paired with its own expectation.
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 0);
				end else begin
					want = pixel_q.pop_front();
					if (m_tuser[0] !== want.valid_res) begin
						report_mismatch("valid_res", m_tuser[0], want.valid_res);
					end
					if (m_tdata[9:0] !== want.x) begin
						report_mismatch("pixel_x", m_tdata[9:0], want.x);
					end
					if (m_tdata[18:10] !== want.y) begin
						report_mismatch("pixel_y", m_tdata[18:10], want.y);
					end
					if (m_tdata[50:19] !== want.addr) begin
						report_mismatch("pixel_address", m_tdata[50:19], want.addr);
					end
					if (m_tdata[58:51] !== want.color) begin
						report_mismatch("pix_color", m_tdata[58:51], want.color);
					end
					if (m_tdata[63:59] !== 5'b0) begin
						report_mismatch("tdata padding", m_tdata[63:59], 0);
					end
					if (m_tlast !== want.last) begin
						report_mismatch("last", m_tlast, want.last);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pixel_q.push_back(rasterize(func_t'(s_tuser[0]), s_tdata));
			end
			pending_count <= pixel_q.size();
		end
	end

endmodule

// ----- dv/line_rasterizer_tb.sv -----
module line_rasterizer_tb;

	import lr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The pixel passes stage one and the output register after its request is accepted.
	localparam int PIPE_DEPTH = 2;
	// Cycles without any accepted request, result or register write before the run is
	// declared hung. The worst legal quiet stretch is a long random stall, well below this.
	localparam int QUIET_LIMIT = 2000;
	// Random requests per phase before its last line starts. That last line can run past
	// the target, so eight phases give at least 560 random requests in all.
	localparam int PHASE_ITEMS = 70;
	localparam int NUM_PHASES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end, [55:48] color
	logic [55:0] s_tdata = '0;
	// [0] func
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [9:0] pixel_x, [18:10] pixel_y, [50:19] pixel_address, [58:51] pix_color,
	// [63:59] zero
	logic [63:0] m_tdata;
	// [0] valid_res
	logic [0:0]  m_tuser;
	logic        m_tlast;

	int mismatches;
	int pending_count;

	// Percentages of cycles in which the request side holds back or the pixel side
	// refuses a result. They change from phase to phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;

	line_rasterizer i_dut (.*);

	line_rasterizer_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// The pixel side decides afresh each cycle whether it will take a result.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// The watchdog only ever ends the run on a hang; normal completion comes from the
	// stimulus process below.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[line_rasterizer] ERROR");
		$finish;
	end

	function automatic int on_screen(int v, int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	// Number of step requests a line needs after its start request, taken from the
	// clamped endpoints: the longer of the two axis distances.
	function automatic int span_of(int xs, int ys, int xe, int ye);
		int ax, ay;
		ax = on_screen(xe, SCREEN_WIDTH - 1) - on_screen(xs, SCREEN_WIDTH - 1);
		ay = on_screen(ye, SCREEN_HEIGHT - 1) - on_screen(ys, SCREEN_HEIGHT - 1);
		if (ax < 0) begin
			ax = -ax;
		end
		if (ay < 0) begin
			ay = -ay;
		end
		return (ax > ay) ? ax : ay;
	endfunction

	// Presents one request and holds it until the block takes it. Valid is left high
	// afterwards, so back-to-back requests keep it up without a dip; whoever comes
	// next either replaces the payload or lowers valid.
	task automatic issue(input func_t f, input logic [55:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic issue_line(input int xs, input int ys, input int xe, input int ye,
			input logic [7:0] ink);
		issue(FUNC_START, {ink, 12'(ye), 12'(xe), 12'(ys), 12'(xs)});
	endtask

	// Step requests carry random payload bits, which the block has to ignore.
	task automatic issue_steps(input int n);
		repeat (n) begin
			issue(FUNC_STEP, 56'({$urandom, $urandom}));
		end
	endtask

	// Stops sending and waits until every pixel that is owed has come back, then lets the
	// pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH + 2) begin
			@(posedge clk);
		end
	endtask

	// The frame base is only changed while nothing is in flight.
	task automatic write_frame_base(input logic [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// One random line, mostly well formed. Short lines dominate so that many of them run
	// to their last pixel; long lines are usually cut short by the next start.
	task automatic random_line();
		int kind, xs, ys, xe, ye, len, steps, pick;
		kind = $urandom_range(99);
		if (kind < 55) begin
			xs = $urandom_range(0, SCREEN_WIDTH - 1);
			ys = $urandom_range(0, SCREEN_HEIGHT - 1);
			xe = xs + int'($urandom_range(0, 40)) - 20;
			ye = ys + int'($urandom_range(0, 40)) - 20;
		end else if (kind < 70) begin
			xs = $urandom_range(0, SCREEN_WIDTH - 1);
			ys = $urandom_range(0, SCREEN_HEIGHT - 1);
			xe = xs + int'($urandom_range(0, 240)) - 120;
			ye = ys + int'($urandom_range(0, 240)) - 120;
		end else if (kind < 85) begin
			// Full signed range, so every coordinate bit toggles and clamping is exercised
			// on both sides of the screen.
			xs = int'($urandom_range(0, 4095)) - 2048;
			ys = int'($urandom_range(0, 4095)) - 2048;
			xe = int'($urandom_range(0, 4095)) - 2048;
			ye = int'($urandom_range(0, 4095)) - 2048;
		end else begin
			xs = int'($urandom_range(0, 4095)) - 2048;
			ys = int'($urandom_range(0, 4095)) - 2048;
			xe = xs;
			ye = ys;
		end
		len = span_of(xs, ys, xe, ye);
		pick = $urandom_range(99);
		if (len > 150) begin
			steps = (pick < 3) ? len + int'($urandom_range(0, 2)) : $urandom_range(0, 30);
		end else if (pick < 70) begin
			steps = len;
		end else if (pick < 85) begin
			steps = len + int'($urandom_range(1, 3));
		end else begin
			steps = $urandom_range(0, len);
		end
		// A little noise: step requests that may land on an idle walker.
		if ($urandom_range(99) < 5) begin
			issue_steps($urandom_range(1, 3));
		end
		issue_line(xs, ys, xe, ye, 8'($urandom));
		issue_steps(steps);
		// Now and then the sender waits for the pipeline to empty completely.
		if ($urandom_range(99) < 2) begin
			drain();
		end
	endtask

	initial begin : stimulus
		int target;
		logic [31:0] base;
		repeat (6) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run without any idling.
		write_frame_base(32'h0004_B000);
		// Steps right after reset find no line and must return an empty result.
		issue_steps(2);
		// Single-pixel line at the origin; the step after it sees an idle walker again.
		issue_line(0, 0, 0, 0, 8'h00);
		issue_steps(1);
		// Most negative start to most positive end, clamped to the two screen corners.
		// It is abandoned after a few pixels by the next start.
		issue_line(-2048, -2048, 2047, 2047, 8'hFF);
		issue_steps(3);
		// Steep line, run to its last pixel plus one step past the end.
		issue_line(10, 10, 11, 14, 8'h3C);
		issue_steps(5);
		// Both directions negative.
		issue_line(20, 20, 17, 18, 8'h5A);
		issue_steps(3);
		// Exact diagonal.
		issue_line(0, 0, 2, 2, 8'hC3);
		issue_steps(2);
		// Vertical line going up.
		issue_line(7, 100, 7, 98, 8'h81);
		issue_steps(2);
		// Far corner given exactly and just past the edge: one pixel, and with the
		// largest frame base its address wraps around.
		write_frame_base(32'hFFFF_FFFF);
		issue_line(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, SCREEN_WIDTH, SCREEN_HEIGHT, 8'hA5);

		// Random part: each phase first sets a new frame base while idle, then picks an
		// idling pattern for the two sides.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					base = 32'h0000_0000;
				end
				1: begin
					base = 32'hFFFF_FFFF;
				end
				3: begin
					// Close enough to the top of the address space that lines wrap.
					base = 32'hFFFF_FFFF - 32'd200000;
				end
				4: begin
					base = 32'h8000_0000;
				end
				default: begin
					base = $urandom;
				end
			endcase
			write_frame_base(base);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 86;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 86;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct <= 36;
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				random_line();
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("[line_rasterizer] OK");
		end else begin
			$display("[line_rasterizer] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/lr_pkg.sv
hw/rtl/lr_core.sv
hw/rtl/line_rasterizer.sv
dv/line_rasterizer_checker.sv
dv/line_rasterizer_tb.sv
